// ===== hdl/bft_pkg.sv =====
package bft_pkg;

    localparam int BUCKETS_DEF = 1024;
    localparam int WAYS_DEF = 4;

    localparam int ENTRY_W = 32 + 32 + 32 + 32 + 48 + 48 + 48;

    localparam logic [1:0] STATUS_UPDATED = 2'd0;
    localparam logic [1:0] STATUS_CREATED = 2'd1;
    localparam logic [1:0] STATUS_FULL    = 2'd2;

    localparam logic [31:0] PKT_MAX  = 32'hFFFF_FFFF;
    localparam logic [47:0] BYTE_MAX = 48'hFFFF_FFFF_FFFF;

    typedef struct packed {
        logic [31:0] source_address;
        logic [31:0] destination_address;
        logic [15:0] source_port;
        logic [15:0] destination_port;
        logic [15:0] packet_length;
        logic [47:0] timestamp_us;
    } t_request;

    typedef struct packed {
        logic [1:0]  status;
        logic [11:0] flow_slot;
        logic [31:0] packets_seen;
        logic [47:0] bytes_seen;
        logic [47:0] first_seen_us;
        logic [47:0] last_seen_us;
    } t_result;

    typedef struct packed {
        logic [31:0] addr_a;
        logic [31:0] addr_b;
        logic [31:0] ports;
        logic [31:0] packets;
        logic [47:0] bytes;
        logic [47:0] first_time;
        logic [47:0] recent_time;
    } t_entry;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_HASH,
        ST_BUCKET,
        ST_READ,
        ST_WRITE,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic clear;
        logic load;
        logic hash;
        logic bucket;
        logic read;
        logic write;
        logic show;
    } t_cmd;

endpackage

// ===== hdl/bft_if.sv =====
interface bft_req_if;
    logic                 valid;
    logic                 ready;
    bft_pkg::t_request    data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface bft_res_if;
    logic                 valid;
    logic                 ready;
    bft_pkg::t_result     data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== hdl/bft_ram.sv =====
module bft_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== hdl/bft_ctrl.sv =====
module bft_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    input  logic              i_clr_done,
    output bft_pkg::t_cmd     o_cmd
);
    bft_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bft_pkg::ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            bft_pkg::ST_CLEAR:  if (i_clr_done) n_state = bft_pkg::ST_IDLE;
            bft_pkg::ST_IDLE:   if (i_in_valid) n_state = bft_pkg::ST_HASH;
            bft_pkg::ST_HASH:   n_state = bft_pkg::ST_BUCKET;
            bft_pkg::ST_BUCKET: n_state = bft_pkg::ST_READ;
            bft_pkg::ST_READ:   n_state = bft_pkg::ST_WRITE;
            bft_pkg::ST_WRITE:  n_state = bft_pkg::ST_OUT;
            bft_pkg::ST_OUT:    if (i_out_ready) n_state = bft_pkg::ST_IDLE;
            default:            n_state = bft_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        o_cmd       = '0;
        case (r_state)
            bft_pkg::ST_CLEAR: o_cmd.clear = 1'b1;
            bft_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            bft_pkg::ST_HASH:   o_cmd.hash = 1'b1;
            bft_pkg::ST_BUCKET: o_cmd.bucket = 1'b1;
            bft_pkg::ST_READ:   o_cmd.read = 1'b1;
            bft_pkg::ST_WRITE:  o_cmd.write = 1'b1;
            bft_pkg::ST_OUT: begin
                o_out_valid = 1'b1;
                o_cmd.show  = 1'b1;
            end
            default: o_in_ready = 1'b0;
        endcase
    end

`ifndef SYNTHESIS
    a_out_after_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.write |=> o_out_valid) else $error("result not shown after write");
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_in_ready && o_out_valid)) else $error("ready while result pending");
    a_load_hashes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> o_cmd.hash) else $error("load not followed by hash");
    a_clear_not_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.clear |-> !o_in_ready) else $error("ready during clearing pass");
`endif
endmodule

// ===== hdl/bft_dp.sv =====
module bft_dp #(
    parameter int BUCKETS = bft_pkg::BUCKETS_DEF,
    parameter int WAYS    = bft_pkg::WAYS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  bft_pkg::t_cmd     i_cmd,
    input  bft_pkg::t_request i_req,
    output bft_pkg::t_result  o_res,
    output logic              o_clr_done
);
    localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam int WW = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int EW = bft_pkg::ENTRY_W;
    // reciprocal ceil(2^(32+BW) / BUCKETS) gives the exact quotient for any 32-bit key
    localparam logic [64:0] MAG_NUM = (65'd1 << (32 + BW)) + 65'(BUCKETS - 1);
    localparam logic [32:0] MAGIC   = 33'(MAG_NUM / 65'(BUCKETS));

    bft_pkg::t_request r_req;
    logic [31:0]       r_hash;
    logic [64:0]       r_prod;
    logic [BW-1:0]     r_bucket;
    logic [BW-1:0]     r_clr_addr;
    logic [31:0]       lo_a, hi_a, lo_p, hi_p, hsh;
    logic [31:0]       quo, rem;
    logic [BW-1:0]     n_bucket;
    logic [BW-1:0]     rd_addr;

    assign lo_a = (i_req.source_address < i_req.destination_address) ?
                  i_req.source_address : i_req.destination_address;
    assign hi_a = (i_req.source_address < i_req.destination_address) ?
                  i_req.destination_address : i_req.source_address;
    assign lo_p = {16'd0, (i_req.source_port < i_req.destination_port) ?
                  i_req.source_port : i_req.destination_port};
    assign hi_p = {16'd0, (i_req.source_port < i_req.destination_port) ?
                  i_req.destination_port : i_req.source_port};
    assign hsh  = lo_a ^ hi_a ^ lo_p ^ hi_p;

    // key modulo bucket count: quotient from the registered product, then subtract
    assign quo = 32'(r_prod >> (32 + BW));
    assign rem = r_hash - quo * 32'(BUCKETS);
    assign n_bucket = rem[BW-1:0];

    // bucket read is issued while the remainder is formed
    assign rd_addr = i_cmd.bucket ? n_bucket : r_bucket;

    assign o_clr_done = (r_clr_addr == BW'(BUCKETS - 1));

    bft_pkg::t_entry rd [WAYS];
    bft_pkg::t_entry r_wentry;
    logic [WAYS-1:0] we;

    for (genvar w = 0; w < WAYS; w++) begin : g_way
        logic [EW-1:0] rdata;
        bft_ram #(.WIDTH(EW), .DEPTH(BUCKETS)) u_ram (
            .i_clk  (i_clk),
            .i_we   (we[w]),
            .i_waddr(r_bucket),
            .i_wdata(r_wentry),
            .i_raddr(rd_addr),
            .o_rdata(rdata)
        );
        assign rd[w] = bft_pkg::t_entry'(rdata);
    end

    // valid bits, one row per bucket, cleared by a pass after reset
    logic [WAYS-1:0] vrow;
    logic            v_we;
    logic [BW-1:0]   v_waddr;
    logic [WAYS-1:0] v_wdata;

    bft_ram #(.WIDTH(WAYS), .DEPTH(BUCKETS)) u_vram (
        .i_clk  (i_clk),
        .i_we   (v_we),
        .i_waddr(v_waddr),
        .i_wdata(v_wdata),
        .i_raddr(rd_addr),
        .o_rdata(vrow)
    );

    logic [31:0] fwd, rev;
    assign fwd = {r_req.source_port, r_req.destination_port};
    assign rev = {r_req.destination_port, r_req.source_port};

    logic              hit, have_free;
    logic [WW-1:0]     hit_way, free_way;
    bft_pkg::t_entry   n_entry;
    logic [48:0]       bsum;

    always_comb begin
        hit = 1'b0;
        have_free = 1'b0;
        hit_way = '0;
        free_way = '0;
        for (int w = 0; w < WAYS; w++) begin
            if (vrow[w]) begin
                if (!hit && ((rd[w].addr_a == r_req.source_address &&
                              rd[w].addr_b == r_req.destination_address &&
                              rd[w].ports == fwd) ||
                             (rd[w].addr_a == r_req.destination_address &&
                              rd[w].addr_b == r_req.source_address &&
                              rd[w].ports == rev))) begin
                    hit = 1'b1;
                    hit_way = WW'(w);
                end
            end else if (!have_free) begin
                have_free = 1'b1;
                free_way = WW'(w);
            end
        end
    end

    always_comb begin
        v_we    = 1'b0;
        v_waddr = r_bucket;
        v_wdata = vrow | (WAYS'(1) << free_way);
        if (i_cmd.clear) begin
            v_we    = 1'b1;
            v_waddr = r_clr_addr;
            v_wdata = '0;
        end else if (i_cmd.read && !hit && have_free) begin
            v_we = 1'b1;
        end
    end

    always_comb begin
        n_entry = rd[hit_way];
        bsum = {1'b0, rd[hit_way].bytes} + {33'd0, r_req.packet_length};
        if (hit) begin
            if (rd[hit_way].packets != bft_pkg::PKT_MAX) begin
                n_entry.packets = rd[hit_way].packets + 32'd1;
            end
            n_entry.bytes = bsum[48] ? bft_pkg::BYTE_MAX : bsum[47:0];
            n_entry.recent_time = r_req.timestamp_us;
        end else begin
            n_entry.addr_a = r_req.source_address;
            n_entry.addr_b = r_req.destination_address;
            n_entry.ports = fwd;
            n_entry.packets = 32'd1;
            n_entry.bytes = {32'd0, r_req.packet_length};
            n_entry.first_time = r_req.timestamp_us;
            n_entry.recent_time = r_req.timestamp_us;
        end
    end

    logic [WW-1:0]    r_way;
    logic             r_write;
    bft_pkg::t_result r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
            r_write <= 1'b0;
        end else begin
            if (i_cmd.clear) r_clr_addr <= r_clr_addr + BW'(1);
            r_write <= 1'b0;
            if (i_cmd.read) begin
                r_write <= hit || have_free;
                r_way <= hit ? hit_way : free_way;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req  <= i_req;
            r_hash <= hsh;
        end
        if (i_cmd.hash) begin
            r_prod <= {33'd0, r_hash} * {32'd0, MAGIC};
        end
        if (i_cmd.bucket) begin
            r_bucket <= n_bucket;
        end
        if (i_cmd.read) begin
            r_wentry <= n_entry;
            if (hit || have_free) begin
                r_res.status <= hit ? bft_pkg::STATUS_UPDATED : bft_pkg::STATUS_CREATED;
                r_res.flow_slot <= 12'(32'(r_bucket) * 32'(WAYS) +
                                   32'(hit ? hit_way : free_way));
                r_res.packets_seen  <= n_entry.packets;
                r_res.bytes_seen    <= n_entry.bytes;
                r_res.first_seen_us <= n_entry.first_time;
                r_res.last_seen_us  <= n_entry.recent_time;
            end else begin
                r_res <= '0;
                r_res.status <= bft_pkg::STATUS_FULL;
            end
        end
    end

    always_comb begin
        we = '0;
        if (i_cmd.write && r_write) we[r_way] = 1'b1;
    end

    assign o_res = r_res;

`ifndef SYNTHESIS
    a_write_one_way: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(we)) else $error("more than one way written");
    a_full_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.show && o_res.status == bft_pkg::STATUS_FULL) |-> !r_write)
        else $error("write on full bucket");
    a_clear_no_entry_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.clear |-> (we == '0)) else $error("entry written during clearing pass");
    a_bucket_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.read |-> (32'(r_bucket) < 32'(BUCKETS))) else $error("bucket out of range");
`endif
endmodule

// ===== hdl/bidirectional_flow_table.sv =====
// Bidirectional flow table: each request (one packet header) hashes a
// direction-independent key into one of BUCKETS buckets of WAYS entries and
// either updates the matching flow (status 0), creates it in the lowest free
// way (status 1), or reports a full bucket (status 2). After reset a clearing
// pass over all BUCKETS buckets zeroes the valid bits; input ready stays low
// meanwhile. An accepted request passes through the hash state (reciprocal
// multiply of the key), the bucket state (modulo and bucket read), the read
// state (way compare) and the write state (write-back); the result is then
// valid in the output state. The next request is taken in the cycle after the
// result is accepted, so only one request is in flight at a time; a stalled
// result holds off the input for as long.
module bidirectional_flow_table #(
    parameter int BUCKETS = bft_pkg::BUCKETS_DEF,
    parameter int WAYS    = bft_pkg::WAYS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    bft_req_if.sink       i_req,
    bft_res_if.source     o_res
);
    bft_pkg::t_cmd cmd;
    logic          clr_done;

    bft_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .o_in_ready (i_req.ready),
        .o_out_valid(o_res.valid),
        .i_out_ready(o_res.ready),
        .i_clr_done (clr_done),
        .o_cmd      (cmd)
    );

    bft_dp #(.BUCKETS(BUCKETS), .WAYS(WAYS)) u_dp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (cmd),
        .i_req     (i_req.data),
        .o_res     (o_res.data),
        .o_clr_done(clr_done)
    );
endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;

    localparam int N_BUCKETS = bft_pkg::BUCKETS_DEF;
    localparam int N_WAYS    = bft_pkg::WAYS_DEF;
    localparam int N_SLOTS   = N_BUCKETS * N_WAYS;
    localparam int HOLD_AT   = 700;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    always #4 i_clk = ~i_clk;

    bft_req_if req_ch ();
    bft_res_if res_ch ();

    bidirectional_flow_table DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch.sink),
        .o_res   (res_ch.source)
    );

    // predicted flow table state
    logic              flow_valid [N_SLOTS];
    bft_pkg::t_entry   flow_entry [N_SLOTS];
    bft_pkg::t_result  pending_results [$];

    int  error_count = 0;
    int  result_count = 0;
    int  created_count = 0;
    int  updated_count = 0;
    int  full_count = 0;
    int  sent_count = 0;
    bit  idle_enable = 1'b1;
    int  hold_cycles = 0;
    bit  hold_done = 1'b0;

    function automatic int flow_bucket_of(bft_pkg::t_request r);
        logic [31:0] lo_a, hi_a, lo_p, hi_p;
        lo_a = (r.source_address < r.destination_address) ? r.source_address
                                                          : r.destination_address;
        hi_a = (r.source_address < r.destination_address) ? r.destination_address
                                                          : r.source_address;
        lo_p = {16'd0, (r.source_port < r.destination_port) ? r.source_port
                                                            : r.destination_port};
        hi_p = {16'd0, (r.source_port < r.destination_port) ? r.destination_port
                                                            : r.source_port};
        return int'((lo_a ^ hi_a ^ lo_p ^ hi_p) % N_BUCKETS);
    endfunction

    function automatic bft_pkg::t_result predict_flow_update(bft_pkg::t_request r);
        bft_pkg::t_result res;
        int          base, slot, free_slot;
        bit          hit, have_free;
        logic [31:0] fwd, rev;
        logic [48:0] sum;
        base = flow_bucket_of(r) * N_WAYS;
        fwd = {r.source_port, r.destination_port};
        rev = {r.destination_port, r.source_port};
        hit = 0;
        have_free = 0;
        slot = 0;
        free_slot = 0;
        res = '0;
        for (int w = 0; w < N_WAYS; w++) begin
            if (flow_valid[base + w]) begin
                if (!hit && ((flow_entry[base + w].addr_a == r.source_address &&
                              flow_entry[base + w].addr_b == r.destination_address &&
                              flow_entry[base + w].ports == fwd) ||
                             (flow_entry[base + w].addr_a == r.destination_address &&
                              flow_entry[base + w].addr_b == r.source_address &&
                              flow_entry[base + w].ports == rev))) begin
                    hit = 1;
                    slot = base + w;
                end
            end else if (!have_free) begin
                have_free = 1;
                free_slot = base + w;
            end
        end
        if (hit) begin
            sum = {1'b0, flow_entry[slot].bytes} + {33'd0, r.packet_length};
            if (flow_entry[slot].packets != bft_pkg::PKT_MAX)
                flow_entry[slot].packets++;
            flow_entry[slot].bytes = sum[48] ? bft_pkg::BYTE_MAX : sum[47:0];
            flow_entry[slot].recent_time = r.timestamp_us;
            res.status = bft_pkg::STATUS_UPDATED;
        end else if (have_free) begin
            slot = free_slot;
            flow_valid[slot] = 1'b1;
            flow_entry[slot] = '{addr_a: r.source_address, addr_b: r.destination_address,
                                 ports: fwd, packets: 32'd1, bytes: 48'(r.packet_length),
                                 first_time: r.timestamp_us, recent_time: r.timestamp_us};
            res.status = bft_pkg::STATUS_CREATED;
        end else begin
            res.status = bft_pkg::STATUS_FULL;
            return res;
        end
        res.flow_slot = slot[11:0];
        res.packets_seen = flow_entry[slot].packets;
        res.bytes_seen = flow_entry[slot].bytes;
        res.first_seen_us = flow_entry[slot].first_time;
        res.last_seen_us = flow_entry[slot].recent_time;
        return res;
    endfunction

    // returns at a negedge, valid high; next call drops or reloads it, the end drops it
    task automatic send_packet(bft_pkg::t_request r);
        while (idle_enable && $urandom_range(99) < 7) begin
            req_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.data <= r;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        pending_results.push_back(predict_flow_update(r));
        sent_count++;
        @(negedge i_clk);
    endtask

    function automatic bft_pkg::t_request random_packet();
        bft_pkg::t_request r;
        r.source_address = $urandom;
        r.destination_address = $urandom;
        r.source_port = 16'($urandom);
        r.destination_port = 16'($urandom);
        r.packet_length = 16'($urandom);
        r.timestamp_us = 48'({$urandom, $urandom});
        return r;
    endfunction

    // result side: stall control and checking
    always @(negedge i_clk) begin
        if (hold_cycles > 0) begin
            res_ch.ready <= 1'b0;
            hold_cycles <= hold_cycles - 1;
        end else if (!hold_done && sent_count == HOLD_AT) begin
            res_ch.ready <= 1'b0;
            hold_cycles <= 200;
            hold_done <= 1'b1;
        end else begin
            res_ch.ready <= !(idle_enable && $urandom_range(99) < 7);
        end
    end

    always @(posedge i_clk) begin
        bft_pkg::t_result want, got;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            got = res_ch.data;
            result_count++;
            if (pending_results.size() == 0) begin
                $error("result with no request outstanding");
                error_count++;
            end else begin
                want = pending_results.pop_front();
                case (want.status)
                    bft_pkg::STATUS_CREATED: created_count++;
                    bft_pkg::STATUS_UPDATED: updated_count++;
                    default: full_count++;
                endcase
                if (got.status !== want.status) begin
                    $error("status expected %0d actual %0d", want.status, got.status);
                    error_count++;
                end
                if (got.flow_slot !== want.flow_slot) begin
                    $error("flow_slot expected %0d actual %0d", want.flow_slot, got.flow_slot);
                    error_count++;
                end
                if (got.packets_seen !== want.packets_seen) begin
                    $error("packets_seen expected %0d actual %0d",
                           want.packets_seen, got.packets_seen);
                    error_count++;
                end
                if (got.bytes_seen !== want.bytes_seen) begin
                    $error("bytes_seen expected %0d actual %0d", want.bytes_seen, got.bytes_seen);
                    error_count++;
                end
                if (got.first_seen_us !== want.first_seen_us) begin
                    $error("first_seen_us expected %0d actual %0d",
                           want.first_seen_us, got.first_seen_us);
                    error_count++;
                end
                if (got.last_seen_us !== want.last_seen_us) begin
                    $error("last_seen_us expected %0d actual %0d",
                           want.last_seen_us, got.last_seen_us);
                    error_count++;
                end
            end
        end
    end

    // field extremes, both directions, zero ports and addresses
    task automatic test_extremes();
        bft_pkg::t_request r;
        r = '{source_address: 32'hFFFF_FFFF, destination_address: 32'h0,
              source_port: 16'hFFFF, destination_port: 16'h0,
              packet_length: 16'hFFFF, timestamp_us: bft_pkg::BYTE_MAX};
        send_packet(r);
        r.timestamp_us = 48'd0;
        r.packet_length = 16'd0;
        send_packet(r);
        r = '{source_address: 32'h0, destination_address: 32'hFFFF_FFFF,
              source_port: 16'h0, destination_port: 16'hFFFF,
              packet_length: 16'd1, timestamp_us: 48'd5};
        send_packet(r);
        send_packet('0);
        send_packet('0);
        r = random_packet();
        r.destination_address = r.source_address;
        r.destination_port = r.source_port;
        send_packet(r);
        send_packet(r);
    endtask

    // fill one bucket past its ways, then hit this test's first flow in reverse direction
    task automatic test_bucket_full();
        bft_pkg::t_request r, first;
        for (int k = 0; k < N_WAYS + 3; k++) begin
            r = random_packet();
            r.source_address = 32'h0A00_0000 + k * N_BUCKETS;
            r.destination_address = 32'h0A00_0000;
            r.source_port = 16'd7;
            r.destination_port = 16'd7;
            if (k == 0) first = r;
            send_packet(r);
        end
        r = first;
        r.source_address = first.destination_address;
        r.destination_address = first.source_address;
        send_packet(r);
        // same bucket, same addresses, other ports do not form the same flow
        r = first;
        r.source_port = 16'd9;
        r.destination_port = 16'd9;
        send_packet(r);
    endtask

    // mostly repeated flows so hits dominate, some fresh noise, some reversed
    task automatic test_random_flows(int count);
        bft_pkg::t_request pool [32];
        bft_pkg::t_request r;
        foreach (pool[i]) pool[i] = random_packet();
        for (int n = 0; n < count; n++) begin
            idle_enable = !(n >= 300 && n < 500);
            case ($urandom_range(9))
                0, 1: r = random_packet();
                2, 3: begin
                    r = pool[$urandom_range(31)];
                    r.source_address = pool[$urandom_range(31)].destination_address;
                    r.destination_address = r.source_address ^ $urandom_range(3);
                end
                default: r = pool[$urandom_range(31)];
            endcase
            if ($urandom_range(1)) begin
                {r.source_address, r.destination_address} =
                    {r.destination_address, r.source_address};
                {r.source_port, r.destination_port} = {r.destination_port, r.source_port};
            end
            r.packet_length = 16'($urandom);
            r.timestamp_us = 48'({$urandom, $urandom});
            send_packet(r);
        end
        idle_enable = 1'b1;
    endtask

    initial begin
        foreach (flow_valid[i]) flow_valid[i] = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.data = '0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        test_extremes();
        test_bucket_full();
        test_random_flows(1130);
        req_ch.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        $display("covered %0d results: %0d new flows, %0d updates, %0d full-bucket drops",
                 result_count, created_count, updated_count, full_count);
        if (error_count == 0 && pending_results.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("status: fail");
        $finish;
    end

endmodule
